[hdl/kmd_pkg.sv]
package kmd_pkg;

  // storage geometry
  localparam int MAX_COLUMNS = 16;
  localparam int MAX_ROWS    = 8;

  // field widths fixed by the item format
  localparam int COL_W   = 4;
  localparam int ROW_W   = 8;
  localparam int CNT_W   = 5;
  localparam int CFG_W   = 5;
  localparam int CFG_IDX_W = 2;

  // lanes cover the rows that are both stored and present in an item
  localparam int LaneCount = (MAX_ROWS < ROW_W) ? MAX_ROWS : ROW_W;
  localparam int ColIdxW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ON_LIMIT  = 2'd0,
    CFG_OFF_LIMIT = 2'd1,
    CFG_COLUMNS   = 2'd2,
    CFG_ROWS      = 2'd3
  } cfg_idx_e;

  localparam logic [3:0]        ON_LIMIT_RST  = 4'd5;
  localparam logic signed [4:0] OFF_LIMIT_RST = -5'sd5;
  localparam logic [4:0]        COLUMNS_RST   = 5'd16;
  localparam logic [3:0]        ROWS_RST      = 4'd8;

  typedef struct packed {
    logic signed [CNT_W-1:0] count;
    logic                    pressed;
  } key_state_t;

  typedef struct packed {
    key_state_t state;
    logic       changed;
  } lane_res_t;

  typedef struct packed {
    logic [COL_W-1:0] column_echo;
    logic [ROW_W-1:0] pressed_keys;
    logic [ROW_W-1:0] changed_keys;
    logic             scan_complete;
  } result_t;

endpackage

[hdl/kmd_if.sv]
interface kmd_item_if;
  import kmd_pkg::*;
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row_levels;

  modport source (output valid, output column, output row_levels, input ready);
  modport sink   (input valid, input column, input row_levels, output ready);
endinterface

interface kmd_result_if;
  import kmd_pkg::*;
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] column_echo;
  logic [ROW_W-1:0] pressed_keys;
  logic [ROW_W-1:0] changed_keys;
  logic             scan_complete;

  modport source (output valid, output column_echo, output pressed_keys,
                  output changed_keys, output scan_complete, input ready);
  modport sink   (input valid, input column_echo, input pressed_keys,
                  input changed_keys, input scan_complete, output ready);
endinterface

[hdl/kmd_lane.sv]
module kmd_lane
  import kmd_pkg::*;
(
  input  key_state_t        state_i,
  input  logic              closed_i,
  input  logic [3:0]        on_limit_i,
  input  logic signed [4:0] off_limit_i,
  output lane_res_t         res_o
);

  logic signed [CNT_W:0] step;
  logic signed [CNT_W:0] on_ext;
  logic signed [CNT_W:0] off_ext;
  logic signed [CNT_W:0] clip_hi;
  logic signed [CNT_W:0] clip;
  logic                  now;

  always_comb begin
    on_ext  = signed'({2'b00, on_limit_i});
    off_ext = {off_limit_i[4], off_limit_i};
    step    = closed_i ? ({state_i.count[CNT_W-1], state_i.count} + 6'sd1)
                       : ({state_i.count[CNT_W-1], state_i.count} - 6'sd1);
    // upper clamp first, then lower
    clip_hi = (step >= on_ext) ? on_ext : step;
    clip    = (clip_hi <= off_ext) ? off_ext : clip_hi;
    // release wins over press when the limits cross
    if (clip <= off_ext) begin
      now = 1'b0;
    end else if (clip >= on_ext) begin
      now = 1'b1;
    end else begin
      now = state_i.pressed;
    end
    res_o.state.count   = clip[CNT_W-1:0];
    res_o.state.pressed = now;
    res_o.changed       = now ^ state_i.pressed;
  end

endmodule

[hdl/kmd_merge.sv]
module kmd_merge
  import kmd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             col_ok_i,
  input  logic [COL_W-1:0] column_i,
  input  logic             scan_complete_i,
  input  lane_res_t        lanes_i [LaneCount],
  output logic             full_o,
  kmd_result_if.source     out_o
);

  result_t    res;
  result_t    slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  // gather lane bits into row vectors
  always_comb begin
    res = '0;
    res.column_echo   = column_i;
    res.scan_complete = scan_complete_i;
    for (int r = 0; r < LaneCount; r++) begin
      res.pressed_keys[r] = col_ok_i & lanes_i[r].state.pressed;
      res.changed_keys[r] = col_ok_i & lanes_i[r].changed;
    end
  end

  assign pop    = out_o.valid & out_o.ready;
  assign full_o = (cnt_q == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= res;
  end

  assign out_o.valid         = (cnt_q != 2'd0);
  assign out_o.column_echo   = slot_q[rd_ptr_q].column_echo;
  assign out_o.pressed_keys  = slot_q[rd_ptr_q].pressed_keys;
  assign out_o.changed_keys  = slot_q[rd_ptr_q].changed_keys;
  assign out_o.scan_complete = slot_q[rd_ptr_q].scan_complete;

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("result buffer count overflow");

endmodule

[hdl/key_matrix_debounce_core.sv]
// channel   | dir | handshake         | payload
// in_i      | in  | valid/ready       | column, row_levels
// out_o     | out | valid/ready       | column_echo, pressed_keys, changed_keys, scan_complete
// cfg       | in  | cfg_we_i          | cfg_idx_i, cfg_wdata_i
//
// one item per cycle while in_i.ready is high; the column's key state is read,
// updated by the row lanes and written back in the accept cycle, so consecutive
// items on the same column need no forwarding
// results appear in the cycle after accept through a two-entry output buffer
// in_i.ready drops only when both buffer entries hold unclaimed results
// async active-low reset clears all counters and pressed bits at once, no sweep
module key_matrix_debounce_core
  import kmd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  kmd_item_if.sink             in_i,
  kmd_result_if.source         out_o
);

  // configuration registers
  logic [3:0]        on_limit_q;
  logic signed [4:0] off_limit_q;
  logic [4:0]        columns_q;
  logic [3:0]        rows_q;

  // per-key state, one row of lanes per column
  key_state_t key_q [MAX_COLUMNS][LaneCount];

  logic               full;
  logic               accept;
  logic               col_ok;
  logic [ColIdxW-1:0] col_idx;
  logic               scan_complete;
  key_state_t         cur   [LaneCount];
  logic               closed [LaneCount];
  lane_res_t          lane_res [LaneCount];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_limit_q  <= ON_LIMIT_RST;
      off_limit_q <= OFF_LIMIT_RST;
      columns_q   <= COLUMNS_RST;
      rows_q      <= ROWS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ON_LIMIT:  on_limit_q  <= cfg_wdata_i[3:0];
        CFG_OFF_LIMIT: off_limit_q <= signed'(cfg_wdata_i);
        CFG_COLUMNS:   columns_q   <= cfg_wdata_i;
        CFG_ROWS:      rows_q      <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = ~full;
  assign accept     = in_i.valid & ~full;

  // columns beyond storage leave state alone and report no keys
  assign col_ok  = (32'(in_i.column) < MAX_COLUMNS);
  assign col_idx = ColIdxW'(in_i.column);

  // zero column count gives all ones after the decrement, never matching
  assign scan_complete = (columns_q != 5'd0) &&
                         ({1'b0, in_i.column} == (columns_q - 5'd1));

  // read the column and feed one lane per row; unused rows read as open
  always_comb begin
    for (int r = 0; r < LaneCount; r++) begin
      cur[r]    = key_q[col_idx][r];
      closed[r] = (4'(r) < rows_q) && !in_i.row_levels[r];
    end
  end

  for (genvar g = 0; g < LaneCount; g++) begin : g_lane
    kmd_lane u_lane (
      .state_i     (cur[g]),
      .closed_i    (closed[g]),
      .on_limit_i  (on_limit_q),
      .off_limit_i (off_limit_q),
      .res_o       (lane_res[g])
    );
  end

  // write back the updated column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MAX_COLUMNS; c++) begin
        for (int r = 0; r < LaneCount; r++) begin
          key_q[c][r] <= '0;
        end
      end
    end else if (accept && col_ok) begin
      for (int r = 0; r < LaneCount; r++) begin
        key_q[col_idx][r] <= lane_res[r].state;
      end
    end
  end

  kmd_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (accept),
    .col_ok_i        (col_ok),
    .column_i        (in_i.column),
    .scan_complete_i (scan_complete),
    .lanes_i         (lane_res),
    .full_o          (full),
    .out_o           (out_o)
  );

  // an accepted item always leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> out_o.valid)
    else $error("accepted item produced no result");

  // an empty output buffer never stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni) !out_o.valid |-> in_i.ready)
    else $error("input stalled with empty output buffer");

  // the lane result lands in storage for the column just processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && col_ok) |=> key_q[$past(col_idx)][0] == $past(lane_res[0].state))
    else $error("key state write-back mismatch");

endmodule
